>>> rtl/pbc_pkg.sv
// Package for the pileup base counter: payload structs, codes and constants.
// Used by every module in rtl/ except pbc_ram; depends on nothing.
package pbc_pkg;

    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int COUNT_BITS_DEF   = 16;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_APPLY = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [2:0] KIND_MATCH = 3'd0;
    localparam logic [2:0] KIND_MISM  = 3'd1;
    localparam logic [2:0] KIND_INS   = 3'd2;
    localparam logic [2:0] KIND_DEL   = 3'd3;
    localparam logic [2:0] KIND_SOFT  = 3'd4;
    localparam logic [2:0] KIND_HARD  = 3'd5;

    localparam logic [2:0] BASE_N = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_SAMEREF = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_INS  = 3'd1;
    localparam logic [2:0] EV_DEL  = 3'd2;
    localparam logic [2:0] EV_SOFT = 3'd3;
    localparam logic [2:0] EV_HARD = 3'd4;

    localparam logic [1:0] REG_WSTART = 2'd0;
    localparam logic [1:0] REG_WEND   = 2'd1;
    localparam logic [1:0] REG_MINS   = 2'd2;
    localparam logic [1:0] REG_MDEL   = 2'd3;

    // Back-end operations chosen by the front end.
    localparam logic [2:0] OP_DONE  = 3'd0; // result fully decided
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_MATCH = 3'd3;
    localparam logic [2:0] OP_MISM  = 3'd4;
    localparam logic [2:0] OP_SINS  = 3'd5;
    localparam logic [2:0] OP_SDEL  = 3'd6;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] ref_position;
        logic [2:0]  seg_kind;
        logic [15:0] seg_len;
        logic [2:0]  base_code;
        logic        clip_at_read_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  event_kind;
        logic [31:0] event_position;
        logic [15:0] event_len;
        logic        event_at_read_end;
        logic [15:0] count_a;
        logic [15:0] count_c;
        logic [15:0] count_g;
        logic [15:0] count_t;
        logic [15:0] count_n;
        logic [15:0] short_ins_total;
        logic [15:0] short_del_total;
    } out_item_t;

    // Classified work handed from front to back. Offsets are window-relative,
    // kept at 32 bits; the back end slices them to the memory index width.
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] offset;   // first index
        logic [31:0] count;    // positions to walk for a match run
        logic [2:0]  base;
        out_item_t   res;      // pre-filled result
    } task_t;

endpackage

>>> rtl/pbc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/pbc_front.sv
// Front end: window check and classification of each item into a back-end task.
// Depends on pbc_pkg.
module pbc_front #(
    parameter int WINDOW_DEPTH = pbc_pkg::WINDOW_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [31:0]      window_start,
    input  logic [31:0]      window_end,
    input  logic [15:0]      min_insertion_len,
    input  logic [15:0]      min_deletion_len,
    input  logic             in_valid,
    input  pbc_pkg::in_item_t in_item,
    output logic             in_ready,
    output logic             task_valid,
    output pbc_pkg::task_t   task_item,
    input  logic             task_ready
);
    localparam logic [32:0] DEPTH_M1 = 33'(WINDOW_DEPTH - 1);

    logic [32:0]    lim, eff_end, we_excl, lo, hi, pos33, hi_raw;
    logic           inw, m_none;
    pbc_pkg::task_t t;
    logic           task_valid_reg;
    pbc_pkg::task_t task_reg;

    // Window bounds and clipping of a match run.
    always_comb
    begin
        lim     = {1'b0, window_start} + DEPTH_M1;
        eff_end = ({1'b0, window_end} < lim) ? {1'b0, window_end} : lim;
        pos33   = {1'b0, in_item.ref_position};
        inw     = (pos33 >= {1'b0, window_start}) && (pos33 <= eff_end);
        we_excl = eff_end + 33'd1;
        hi_raw  = pos33 + {17'd0, in_item.seg_len};
        lo      = (pos33 < {1'b0, window_start}) ? {1'b0, window_start} : pos33;
        hi      = (hi_raw > we_excl) ? we_excl : hi_raw;
        m_none  = (in_item.seg_len == 16'd0) || (lo >= hi);
    end

    // Classification.
    always_comb
    begin
        t          = '0;
        t.base     = in_item.base_code;
        t.offset   = 32'(pos33 - {1'b0, window_start});
        t.res.status = pbc_pkg::ST_OK;
        case (in_item.command)
            pbc_pkg::CMD_LOAD:
            begin
                if (inw) t.op = pbc_pkg::OP_LOAD;
                else     t.res.status = pbc_pkg::ST_OUTSIDE;
            end
            pbc_pkg::CMD_READ:
            begin
                if (inw) t.op = pbc_pkg::OP_READ;
                else     t.res.status = pbc_pkg::ST_OUTSIDE;
            end
            pbc_pkg::CMD_APPLY:
            begin
                if (in_item.seg_kind > pbc_pkg::KIND_HARD)
                begin
                    t.res.status = pbc_pkg::ST_INVALID;
                end
                else if (in_item.seg_kind == pbc_pkg::KIND_MATCH)
                begin
                    if (m_none)
                    begin
                        t.res.status = pbc_pkg::ST_OUTSIDE;
                    end
                    else
                    begin
                        t.op     = pbc_pkg::OP_MATCH;
                        t.offset = 32'(lo - {1'b0, window_start});
                        t.count  = 32'(hi - lo);
                    end
                end
                else if (!inw)
                begin
                    t.res.status = pbc_pkg::ST_OUTSIDE;
                end
                else if (in_item.seg_kind == pbc_pkg::KIND_MISM)
                begin
                    if (in_item.base_code > pbc_pkg::BASE_N)
                        t.res.status = pbc_pkg::ST_INVALID;
                    else
                        t.op = pbc_pkg::OP_MISM;
                end
                else if (in_item.seg_kind == pbc_pkg::KIND_INS)
                begin
                    if (in_item.seg_len >= min_insertion_len)
                    begin
                        t.res.event_kind     = pbc_pkg::EV_INS;
                        t.res.event_position = in_item.ref_position;
                        t.res.event_len      = in_item.seg_len;
                    end
                    else
                    begin
                        t.op = pbc_pkg::OP_SINS;
                    end
                end
                else if (in_item.seg_kind == pbc_pkg::KIND_DEL)
                begin
                    if (in_item.seg_len >= min_deletion_len)
                    begin
                        t.res.event_kind     = pbc_pkg::EV_DEL;
                        t.res.event_position = in_item.ref_position;
                        t.res.event_len      = in_item.seg_len;
                    end
                    else
                    begin
                        t.op = pbc_pkg::OP_SDEL;
                    end
                end
                else
                begin
                    t.res.event_kind = (in_item.seg_kind == pbc_pkg::KIND_SOFT)
                                       ? pbc_pkg::EV_SOFT : pbc_pkg::EV_HARD;
                    t.res.event_position    = in_item.ref_position;
                    t.res.event_len         = in_item.seg_len;
                    t.res.event_at_read_end = in_item.clip_at_read_end;
                end
            end
            default:
            begin
                t.res.status = pbc_pkg::ST_INVALID;
            end
        endcase
    end

    // One-entry queue toward the back end.
    assign in_ready   = !task_valid_reg || task_ready;
    assign task_valid = task_valid_reg;
    assign task_item  = task_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            task_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            task_reg <= t;
        end
    end
endmodule

>>> rtl/pbc_back.sv
// Back end: sequencer over the reference, count and short indel memories.
// Depends on pbc_pkg and pbc_ram.
module pbc_back #(
    parameter int WINDOW_DEPTH = pbc_pkg::WINDOW_DEPTH_DEF,
    parameter int COUNT_BITS   = pbc_pkg::COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              task_valid,
    input  pbc_pkg::task_t    task_item,
    output logic              task_ready,
    output logic              res_valid,
    output pbc_pkg::out_item_t res_item,
    input  logic              res_ready
);
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int RD = (WINDOW_DEPTH > 1) ? WINDOW_DEPTH : 2;
    localparam int CW = COUNT_BITS;
    localparam logic [CW-1:0] CMAX = '1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RDREF, S_WREF, S_RDCNT, S_WCNT, S_RDALL, S_WALL, S_OUT
    } state_t;

    state_t         state_reg;
    logic [AW:0]    clr_reg;
    logic [AW-1:0]  addr_reg;
    logic [31:0]    left_reg;
    logic [2:0]     op_reg;
    logic [2:0]     base_reg;
    logic [2:0]     sel_reg;
    pbc_pkg::out_item_t res_reg;
    logic           ovalid_reg;

    // Memories: reference bases, five base count banks, short ins/del.
    logic          ref_we;
    logic [2:0]    ref_wd, ref_rd;
    logic [4:0]    cnt_we;
    logic [CW-1:0] cnt_wd [5];
    logic [CW-1:0] cnt_rd [5];
    logic          sins_we, sdel_we;
    logic [CW-1:0] sins_wd, sdel_wd, sins_rd, sdel_rd;
    logic [AW-1:0] maddr;
    logic          clearing;

    assign clearing = (state_reg == S_CLEAR);
    assign maddr    = clearing ? clr_reg[AW-1:0] : addr_reg;

    pbc_ram #(.WIDTH(3), .DEPTH(RD)) u_ref (
        .clk(clk), .we(ref_we), .addr(maddr), .wdata(ref_wd), .rdata(ref_rd)
    );

    for (genvar b = 0; b < 5; b++)
    begin : g_cnt
        pbc_ram #(.WIDTH(CW), .DEPTH(RD)) u_cnt (
            .clk(clk), .we(cnt_we[b]), .addr(maddr), .wdata(cnt_wd[b]),
            .rdata(cnt_rd[b])
        );
    end

    pbc_ram #(.WIDTH(CW), .DEPTH(RD)) u_sins (
        .clk(clk), .we(sins_we), .addr(maddr), .wdata(sins_wd), .rdata(sins_rd)
    );
    pbc_ram #(.WIDTH(CW), .DEPTH(RD)) u_sdel (
        .clk(clk), .we(sdel_we), .addr(maddr), .wdata(sdel_wd), .rdata(sdel_rd)
    );

    // Counter bank selected for a read-modify-write.
    logic [CW-1:0] sel_cnt, sel_inc, ind_cnt;
    always_comb
    begin
        sel_cnt = '0;
        case (sel_reg)
            3'd0: sel_cnt = cnt_rd[0];
            3'd1: sel_cnt = cnt_rd[1];
            3'd2: sel_cnt = cnt_rd[2];
            3'd3: sel_cnt = cnt_rd[3];
            3'd4: sel_cnt = cnt_rd[4];
            default: sel_cnt = '0;
        endcase
        sel_inc = (sel_cnt == CMAX) ? sel_cnt : sel_cnt + 1'b1;
        ind_cnt = (op_reg == pbc_pkg::OP_SINS) ? sins_rd : sdel_rd;
        ind_cnt = (ind_cnt == CMAX) ? ind_cnt : ind_cnt + 1'b1;
    end

    // Memory write strobes.
    always_comb
    begin
        ref_we  = (state_reg == S_WREF) || clearing;
        ref_wd  = clearing ? 3'd0 : base_reg;
        sins_we = clearing || (state_reg == S_WALL && op_reg == pbc_pkg::OP_SINS);
        sdel_we = clearing || (state_reg == S_WALL && op_reg == pbc_pkg::OP_SDEL);
        sins_wd = clearing ? '0 : ind_cnt;
        sdel_wd = clearing ? '0 : ind_cnt;
        for (int b = 0; b < 5; b++)
        begin
            cnt_we[b] = clearing ||
                        (state_reg == S_WCNT && sel_reg == 3'(b));
            cnt_wd[b] = clearing ? '0 : sel_inc;
        end
    end

    assign task_ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign res_valid  = ovalid_reg;
    assign res_item   = res_reg;

    // Sequencer with registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            addr_reg   <= '0;
            left_reg   <= '0;
            op_reg     <= pbc_pkg::OP_DONE;
            base_reg   <= '0;
            sel_reg    <= '0;
            res_reg    <= '0;
        end
        else
        begin
            if (ovalid_reg && res_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(RD - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (task_valid && task_ready)
                    begin
                        res_reg  <= task_item.res;
                        op_reg   <= task_item.op;
                        base_reg <= task_item.base;
                        addr_reg <= task_item.offset[AW-1:0];
                        left_reg <= task_item.count;
                        sel_reg  <= task_item.base;
                        case (task_item.op)
                            pbc_pkg::OP_LOAD:  state_reg <= S_WREF;
                            pbc_pkg::OP_MATCH: state_reg <= S_RDREF;
                            pbc_pkg::OP_MISM:  state_reg <= S_RDREF;
                            pbc_pkg::OP_READ:  state_reg <= S_RDALL;
                            pbc_pkg::OP_SINS:  state_reg <= S_RDALL;
                            pbc_pkg::OP_SDEL:  state_reg <= S_RDALL;
                            default:           state_reg <= S_OUT;
                        endcase
                    end
                end
                S_WREF:
                begin
                    state_reg <= S_OUT;
                end
                S_RDREF:
                begin
                    // Reference and counters read; pick the bank next.
                    state_reg <= S_RDCNT;
                end
                S_RDCNT:
                begin
                    if (op_reg == pbc_pkg::OP_MATCH)
                    begin
                        sel_reg   <= ref_rd;
                        state_reg <= (ref_rd <= pbc_pkg::BASE_N) ? S_WCNT : S_WALL;
                    end
                    else if (base_reg != ref_rd || base_reg == pbc_pkg::BASE_N)
                    begin
                        state_reg <= S_WCNT;
                    end
                    else
                    begin
                        res_reg.status <= pbc_pkg::ST_SAMEREF;
                        state_reg      <= S_OUT;
                    end
                end
                S_WCNT, S_WALL:
                begin
                    if (op_reg == pbc_pkg::OP_MATCH && left_reg > 32'd1)
                    begin
                        left_reg  <= left_reg - 32'd1;
                        addr_reg  <= addr_reg + 1'b1;
                        state_reg <= S_RDREF;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_RDALL:
                begin
                    if (op_reg == pbc_pkg::OP_READ)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_WALL;
                end
                S_OUT:
                begin
                    if (op_reg == pbc_pkg::OP_READ)
                    begin
                        res_reg.count_a         <= 16'(cnt_rd[0]);
                        res_reg.count_c         <= 16'(cnt_rd[1]);
                        res_reg.count_g         <= 16'(cnt_rd[2]);
                        res_reg.count_t         <= 16'(cnt_rd[3]);
                        res_reg.count_n         <= 16'(cnt_rd[4]);
                        res_reg.short_ins_total <= 16'(sins_rd);
                        res_reg.short_del_total <= 16'(sdel_rd);
                    end
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Nothing is taken in while the memories are being cleared.
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !task_ready) else $error("task taken during clear");
    // A result is only raised by the output step.
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == S_OUT)) else $error("stray result");
    // A match walk never runs with zero positions left.
    a_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDREF && op_reg == pbc_pkg::OP_MATCH) |-> left_reg != 32'd0)
        else $error("empty match walk");
endmodule

>>> rtl/pileup_base_counter.sv
// Top level of the pileup base counter: configuration registers, front and back.
// Depends on pbc_pkg, pbc_front, pbc_back.
//
//  channel  | direction | handshake        | payload
//  input    | in        | push / full      | in_data  (pbc_pkg::in_item_t)
//  result   | out       | pop / empty      | out_data (pbc_pkg::out_item_t)
//  config   | in        | cfg_we           | cfg_index, cfg_data
//
// After reset the back end clears every entry of its memories; the front queue
// takes one item in that time, and full then stays high until the clear is done.
// A match run walks each covered window position in turn through read, select and write.
// The back end takes its next item only after the result is popped; one front queue
// entry lets the input accept one item while the back end is busy.
module pileup_base_counter #(
    parameter int WINDOW_DEPTH = pbc_pkg::WINDOW_DEPTH_DEF,
    parameter int COUNT_BITS   = pbc_pkg::COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  pbc_pkg::in_item_t  in_data,
    output logic               empty,
    input  logic               pop,
    output pbc_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    logic [31:0] window_start_reg, window_end_reg;
    logic [15:0] min_ins_reg, min_del_reg;
    logic           in_ready, task_valid, task_ready, res_valid;
    pbc_pkg::task_t task_item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= 32'd1;
            window_end_reg   <= 32'd4096;
            min_ins_reg      <= 16'd0;
            min_del_reg      <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pbc_pkg::REG_WSTART: window_start_reg <= cfg_data;
                pbc_pkg::REG_WEND:   window_end_reg   <= cfg_data;
                pbc_pkg::REG_MINS:   min_ins_reg      <= cfg_data[15:0];
                pbc_pkg::REG_MDEL:   min_del_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign full  = !in_ready;
    assign empty = !res_valid;

    pbc_front #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .window_start(window_start_reg), .window_end(window_end_reg),
        .min_insertion_len(min_ins_reg), .min_deletion_len(min_del_reg),
        .in_valid(push), .in_item(in_data), .in_ready(in_ready),
        .task_valid(task_valid), .task_item(task_item), .task_ready(task_ready)
    );

    pbc_back #(.WINDOW_DEPTH(WINDOW_DEPTH), .COUNT_BITS(COUNT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .task_valid(task_valid), .task_item(task_item), .task_ready(task_ready),
        .res_valid(res_valid), .res_item(out_data), .res_ready(pop)
    );
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for pileup_base_counter: directed and random commands,
// checked result by result against an in-bench model. Depends on pbc_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH       = pbc_pkg::WINDOW_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 20000000;

    // Codes that the package does not name: bases and out-of-range values.
    localparam logic [1:0] CMD_BAD   = 2'd3;
    localparam logic [2:0] KIND_BAD6 = 3'd6;
    localparam logic [2:0] KIND_BAD7 = 3'd7;
    localparam logic [2:0] BASE_A    = 3'd0;
    localparam logic [2:0] BASE_C    = 3'd1;
    localparam logic [2:0] BASE_G    = 3'd2;
    localparam logic [2:0] BASE_T    = 3'd3;
    localparam logic [2:0] BASE_BAD5 = 3'd5;
    localparam logic [2:0] BASE_BAD7 = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    pbc_pkg::in_item_t  in_data;
    logic               empty;
    logic               pop;
    pbc_pkg::out_item_t out_data;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    // Model state: reference bases, counters and the configuration registers.
    logic [2:0]  ref_bases [DEPTH];
    bit          ref_loaded [DEPTH];
    logic [15:0] base_counts [5][DEPTH];
    logic [15:0] short_ins [DEPTH];
    logic [15:0] short_del [DEPTH];
    logic [31:0] win_start;
    logic [31:0] win_end;
    logic [15:0] min_ins;
    logic [15:0] min_del;

    pbc_pkg::out_item_t expected_counts [$];
    int          errors;
    int          cycles;
    bit          tx_fast;
    bit          rx_fast;
    int          rx_hold;

    pileup_base_counter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Cycle counter and timeout guard.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Last covered position after clamping to the window depth.
    function automatic logic [63:0] window_last();
        logic [63:0] lim;
        lim = {32'd0, win_start} + 64'(DEPTH) - 64'd1;
        return ({32'd0, win_end} < lim) ? {32'd0, win_end} : lim;
    endfunction

    function automatic bit in_window(logic [63:0] pos);
        return pos >= {32'd0, win_start} && pos <= window_last();
    endfunction

    function automatic logic [15:0] sat_inc(logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    // True when a match or mismatch would touch a reference entry never loaded.
    function automatic bit hits_unwritten(pbc_pkg::in_item_t it);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] p;
        if (it.command != pbc_pkg::CMD_APPLY)
            return 0;
        if (it.seg_kind == pbc_pkg::KIND_MISM)
            return in_window({32'd0, it.ref_position})
                && !ref_loaded[(it.ref_position - win_start) % DEPTH];
        if (it.seg_kind != pbc_pkg::KIND_MATCH)
            return 0;
        lo = {32'd0, it.ref_position};
        hi = {32'd0, it.ref_position} + {48'd0, it.seg_len};
        if (lo < {32'd0, win_start})
            lo = {32'd0, win_start};
        if (hi > window_last() + 64'd1)
            hi = window_last() + 64'd1;
        for (p = lo; p < hi; p++)
        begin
            if (!ref_loaded[(p - {32'd0, win_start}) % DEPTH])
                return 1;
        end
        return 0;
    endfunction

    // Works out the result of one command and updates the counter state.
    function automatic pbc_pkg::out_item_t predict_counts(pbc_pkg::in_item_t it);
        pbc_pkg::out_item_t r;
        logic [63:0] pos;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] p;
        logic [2:0]  rb;
        bit          inw;
        int          idx;
        int          k;
        r   = '0;
        pos = {32'd0, it.ref_position};
        inw = in_window(pos);
        idx = inw ? int'((pos - {32'd0, win_start}) % DEPTH) : 0;
        if (it.command == pbc_pkg::CMD_LOAD)
        begin
            if (inw)
            begin
                ref_bases[idx]  = it.base_code;
                ref_loaded[idx] = 1;
            end
            else
                r.status = pbc_pkg::ST_OUTSIDE;
        end
        else if (it.command == pbc_pkg::CMD_READ)
        begin
            if (inw)
            begin
                r.count_a         = base_counts[0][idx];
                r.count_c         = base_counts[1][idx];
                r.count_g         = base_counts[2][idx];
                r.count_t         = base_counts[3][idx];
                r.count_n         = base_counts[4][idx];
                r.short_ins_total = short_ins[idx];
                r.short_del_total = short_del[idx];
            end
            else
                r.status = pbc_pkg::ST_OUTSIDE;
        end
        else if (it.command != pbc_pkg::CMD_APPLY || it.seg_kind > pbc_pkg::KIND_HARD)
            r.status = pbc_pkg::ST_INVALID;
        else if (it.seg_kind == pbc_pkg::KIND_MATCH)
        begin
            lo = pos;
            hi = pos + {48'd0, it.seg_len};
            if (lo < {32'd0, win_start})
                lo = {32'd0, win_start};
            if (hi > window_last() + 64'd1)
                hi = window_last() + 64'd1;
            if (it.seg_len == 16'd0 || lo >= hi)
                r.status = pbc_pkg::ST_OUTSIDE;
            else
            begin
                for (p = lo; p < hi; p++)
                begin
                    k  = int'((p - {32'd0, win_start}) % DEPTH);
                    rb = ref_bases[k];
                    if (rb <= pbc_pkg::BASE_N)
                        base_counts[rb][k] = sat_inc(base_counts[rb][k]);
                end
            end
        end
        else if (!inw)
            r.status = pbc_pkg::ST_OUTSIDE;
        else if (it.seg_kind == pbc_pkg::KIND_MISM)
        begin
            if (it.base_code > pbc_pkg::BASE_N)
                r.status = pbc_pkg::ST_INVALID;
            else if (it.base_code != ref_bases[idx] || it.base_code == pbc_pkg::BASE_N)
                base_counts[it.base_code][idx] = sat_inc(base_counts[it.base_code][idx]);
            else
                r.status = pbc_pkg::ST_SAMEREF;
        end
        else if (it.seg_kind == pbc_pkg::KIND_INS)
        begin
            if (it.seg_len >= min_ins)
            begin
                r.event_kind     = pbc_pkg::EV_INS;
                r.event_position = it.ref_position;
                r.event_len      = it.seg_len;
            end
            else
                short_ins[idx] = sat_inc(short_ins[idx]);
        end
        else if (it.seg_kind == pbc_pkg::KIND_DEL)
        begin
            if (it.seg_len >= min_del)
            begin
                r.event_kind     = pbc_pkg::EV_DEL;
                r.event_position = it.ref_position;
                r.event_len      = it.seg_len;
            end
            else
                short_del[idx] = sat_inc(short_del[idx]);
        end
        else
        begin
            r.event_kind        = (it.seg_kind == pbc_pkg::KIND_SOFT)
                                  ? pbc_pkg::EV_SOFT : pbc_pkg::EV_HARD;
            r.event_position    = it.ref_position;
            r.event_len         = it.seg_len;
            r.event_at_read_end = it.clip_at_read_end;
        end
        return r;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // Sends one item after a random gap and records its expected result.
    task automatic send_item(pbc_pkg::in_item_t it);
        int gap;
        if (hits_unwritten(it))
            it.seg_kind = pbc_pkg::KIND_DEL;
        gap = tx_fast ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expected_counts.insert(expected_counts.size(), predict_counts(it));
    endtask

    // Waits until every expected result has arrived and the block is quiet.
    task automatic drain();
        push <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Writes all four registers, one per cycle, while the block is idle.
    task automatic set_config(logic [31:0] ws, logic [31:0] we, logic [15:0] mi,
                              logic [15:0] md);
        logic [31:0] vals [4];
        int          i;
        vals = '{ws, we, {16'd0, mi}, {16'd0, md}};
        drain();
        for (i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we    <= 1'b0;
        win_start = ws;
        win_end   = we;
        min_ins   = mi;
        min_del   = md;
    endtask

    function automatic pbc_pkg::in_item_t make_item(logic [1:0] cmd, logic [31:0] pos,
                                                    logic [2:0] kind, logic [15:0] len,
                                                    logic [2:0] base, logic at_end);
        pbc_pkg::in_item_t it;
        it = '{cmd, pos, kind, len, base, at_end};
        return it;
    endfunction

    // Loads random reference codes at the first positions of the window.
    task automatic load_span(int n);
        int i;
        if (window_last() < {32'd0, win_start})
            return;
        if (window_last() - {32'd0, win_start} + 64'd1 < 64'(n))
            n = int'(window_last() - {32'd0, win_start} + 64'd1);
        for (i = 0; i < n; i++)
            send_item(make_item(pbc_pkg::CMD_LOAD, win_start + 32'(i), 3'($urandom),
                                16'($urandom), 3'($urandom_range(0, 7)), 1'($urandom)));
    endtask

    // A position near the window start most of the time, anywhere otherwise.
    function automatic logic [31:0] near_pos();
        logic [63:0] span;
        if ($urandom_range(0, 99) < 15)
            return $urandom;
        span = (window_last() >= {32'd0, win_start})
               ? window_last() - {32'd0, win_start} : 64'd8;
        if (span > 64'd80)
            span = 64'd80;
        return win_start - 32'd2 + 32'($urandom_range(0, int'(span) + 4));
    endfunction

    function automatic logic [15:0] rand_len(logic [15:0] thr);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 16'($urandom_range(0, 12));
        if (r < 8)
            return 16'(32'(thr) + $urandom_range(0, 2) - 32'd1);
        return 16'($urandom);
    endfunction

    // One random command, weighted toward well-formed traffic.
    function automatic pbc_pkg::in_item_t random_item();
        pbc_pkg::in_item_t it;
        int                r;
        it = make_item(pbc_pkg::CMD_APPLY, near_pos(), pbc_pkg::KIND_MATCH, 16'd0,
                       3'($urandom_range(0, 4)), 1'($urandom));
        r  = $urandom_range(0, 99);
        if (r < 12)
        begin
            it.command   = pbc_pkg::CMD_LOAD;
            it.base_code = 3'($urandom_range(0, 7));
        end
        else if (r < 27)
            it.command = pbc_pkg::CMD_READ;
        else if (r < 45)
            it.seg_len = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 12));
        else if (r < 65)
        begin
            it.seg_kind = pbc_pkg::KIND_MISM;
            if ($urandom_range(0, 9) == 0)
                it.base_code = 3'($urandom_range(5, 7));
        end
        else if (r < 75)
        begin
            it.seg_kind = pbc_pkg::KIND_INS;
            it.seg_len  = rand_len(min_ins);
        end
        else if (r < 83)
        begin
            it.seg_kind = pbc_pkg::KIND_DEL;
            it.seg_len  = rand_len(min_del);
        end
        else if (r < 92)
        begin
            it.seg_kind = ($urandom_range(0, 1) != 0) ? pbc_pkg::KIND_SOFT
                                                      : pbc_pkg::KIND_HARD;
            it.seg_len  = 16'($urandom);
        end
        else if (r < 96)
            it.seg_kind = ($urandom_range(0, 1) != 0) ? KIND_BAD7 : KIND_BAD6;
        else
            it.command = CMD_BAD;
        if (r >= 83)
        begin
            it.base_code = 3'($urandom);
            it.seg_len   = 16'($urandom);
        end
        return it;
    endfunction

    task automatic run_random(int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                tx_fast = !tx_fast;
            if ($urandom_range(0, 39) == 0)
                rx_fast = !rx_fast;
            send_item(random_item());
        end
    endtask

    // Result side: random stalls, an occasional long hold-off.
    initial
    begin
        int w;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = rx_fast ? 0 : $urandom_range(0, 16);
            if (rx_hold > 0)
            begin
                w       = rx_hold;
                rx_hold = 0;
            end
            if (w > 0)
            begin
                pop <= 1'b0;
                repeat (w) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    // Compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        pbc_pkg::out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_counts.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = expected_counts.pop_front();
                if (out_data.status !== want.status)
                    report("status", 64'(out_data.status), 64'(want.status));
                if (out_data.event_kind !== want.event_kind)
                    report("event_kind", 64'(out_data.event_kind), 64'(want.event_kind));
                if (out_data.event_position !== want.event_position)
                    report("event_position", 64'(out_data.event_position),
                           64'(want.event_position));
                if (out_data.event_len !== want.event_len)
                    report("event_len", 64'(out_data.event_len), 64'(want.event_len));
                if (out_data.event_at_read_end !== want.event_at_read_end)
                    report("event_at_read_end", 64'(out_data.event_at_read_end),
                           64'(want.event_at_read_end));
                if (out_data.count_a !== want.count_a)
                    report("count_a", 64'(out_data.count_a), 64'(want.count_a));
                if (out_data.count_c !== want.count_c)
                    report("count_c", 64'(out_data.count_c), 64'(want.count_c));
                if (out_data.count_g !== want.count_g)
                    report("count_g", 64'(out_data.count_g), 64'(want.count_g));
                if (out_data.count_t !== want.count_t)
                    report("count_t", 64'(out_data.count_t), 64'(want.count_t));
                if (out_data.count_n !== want.count_n)
                    report("count_n", 64'(out_data.count_n), 64'(want.count_n));
                if (out_data.short_ins_total !== want.short_ins_total)
                    report("short_ins_total", 64'(out_data.short_ins_total),
                           64'(want.short_ins_total));
                if (out_data.short_del_total !== want.short_del_total)
                    report("short_del_total", 64'(out_data.short_del_total),
                           64'(want.short_del_total));
            end
        end
    end

    // Field extremes, every command and segment kind, and the special cases.
    task automatic test_directed();
        send_item(make_item(pbc_pkg::CMD_LOAD, 32'd1, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_LOAD, 32'd2, pbc_pkg::KIND_MATCH, 16'd0,
                            pbc_pkg::BASE_N, 1'b0));
        send_item(make_item(pbc_pkg::CMD_LOAD, 32'd3, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_BAD7, 1'b0));
        send_item(make_item(pbc_pkg::CMD_LOAD, 32'd4, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_T, 1'b0));
        send_item(make_item(pbc_pkg::CMD_LOAD, 32'd4096, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_G, 1'b0));
        send_item(make_item(pbc_pkg::CMD_LOAD, 32'd0, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_C, 1'b0));
        // Position three holds a code above four and is skipped by the run.
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd1, pbc_pkg::KIND_MATCH, 16'd4,
                            BASE_A, 1'b0));
        // Run clipped at the window end.
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd4096, pbc_pkg::KIND_MATCH, 16'hFFFF,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd1, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd1, pbc_pkg::KIND_MISM, 16'd1,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd2, pbc_pkg::KIND_MISM, 16'd1,
                            pbc_pkg::BASE_N, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd1, pbc_pkg::KIND_MISM, 16'd1,
                            BASE_T, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd1, pbc_pkg::KIND_MISM, 16'd1,
                            BASE_BAD5, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd5000, pbc_pkg::KIND_MISM, 16'd1,
                            BASE_C, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd2, pbc_pkg::KIND_INS, 16'd0,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd4096, pbc_pkg::KIND_DEL, 16'hFFFF,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd3, pbc_pkg::KIND_SOFT, 16'd7,
                            BASE_A, 1'b1));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd1, pbc_pkg::KIND_HARD, 16'hFFFF,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd1, KIND_BAD6, 16'd1, BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd1, KIND_BAD7, 16'd1, BASE_BAD7, 1'b1));
        send_item(make_item(CMD_BAD, 32'hFFFF_FFFF, KIND_BAD7, 16'hFFFF, BASE_BAD7, 1'b1));
        send_item(make_item(pbc_pkg::CMD_READ, 32'd1, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_READ, 32'd2, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_READ, 32'd4096, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_READ, 32'hFFFF_FFFF, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_A, 1'b0));
    endtask

    // Short indels below the thresholds, events at and above them.
    task automatic test_thresholds();
        set_config(32'd1, 32'd4096, 16'hFFFF, 16'd5);
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd2, pbc_pkg::KIND_INS, 16'hFFFE,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd2, pbc_pkg::KIND_INS, 16'hFFFF,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd2, pbc_pkg::KIND_DEL, 16'd4,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'd2, pbc_pkg::KIND_DEL, 16'd5,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_READ, 32'd2, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_A, 1'b0));
        run_random(30);
    endtask

    // Window at the top of the position range, empty, and clamped.
    task automatic test_window_extremes();
        set_config(32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'd3, 16'd0);
        load_span(16);
        send_item(make_item(pbc_pkg::CMD_APPLY, 32'hFFFF_FFF8, pbc_pkg::KIND_MATCH,
                            16'hFFFF, BASE_A, 1'b0));
        run_random(30);
        set_config(32'd200, 32'd199, 16'd0, 16'd2);
        run_random(20);
        set_config(32'd0, 32'hFFFF_FFFF, 16'd2, 16'd2);
        load_span(16);
        send_item(make_item(pbc_pkg::CMD_READ, 32'd4095, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_A, 1'b0));
        send_item(make_item(pbc_pkg::CMD_READ, 32'd4096, pbc_pkg::KIND_MATCH, 16'd0,
                            BASE_A, 1'b0));
        run_random(30);
    endtask

    // Receiver holds off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        set_config(32'd10, 32'd73, 16'd4, 16'd4);
        load_span(32);
        drain();
        tx_fast = 1;
        rx_hold = 400;
        run_random(40);
        tx_fast = 0;
    endtask

    // Random traffic over several random settings.
    task automatic test_random();
        int          ph;
        logic [31:0] ws;
        for (ph = 0; ph < 5; ph++)
        begin
            ws = (ph % 2 == 0) ? $urandom : $urandom_range(0, 5000);
            set_config(ws, ws + 32'($urandom_range(0, 100)),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 6)),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 6)));
            load_span(16);
            run_random(30);
        end
    endtask

    initial
    begin
        int i;
        rst_n     = 1'b0;
        push      = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = pbc_pkg::REG_WSTART;
        cfg_data  = '0;
        errors    = 0;
        cycles    = 0;
        tx_fast   = 0;
        rx_fast   = 0;
        rx_hold   = 0;
        win_start = 32'd1;
        win_end   = 32'd4096;
        min_ins   = 16'd0;
        min_del   = 16'd0;
        for (i = 0; i < DEPTH; i++)
        begin
            ref_bases[i]      = '0;
            ref_loaded[i]     = 0;
            short_ins[i]      = '0;
            short_del[i]      = '0;
            base_counts[0][i] = '0;
            base_counts[1][i] = '0;
            base_counts[2][i] = '0;
            base_counts[3][i] = '0;
            base_counts[4][i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_thresholds();
        test_window_extremes();
        test_backpressure();
        test_random();

        drain();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> pileup_base_counter.f
rtl/pbc_pkg.sv
rtl/pbc_ram.sv
rtl/pbc_front.sv
rtl/pbc_back.sv
rtl/pileup_base_counter.sv
tb/sv/testbench.sv
